### design/assert_macros.svh
// Assertion macros shared by the periodic minimum-image distance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks a property on every clock edge outside reset.
`define PMID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pmid assertion failed");
// Checks that a condition implies a consequence in the same cycle.
`define PMID_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmid implication failed");
// Checks that a condition implies a consequence in the next cycle.
`define PMID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmid next-cycle check failed");
`else
`define PMID_ASSERT(lbl, prop)
`define PMID_ASSERT_IMP(lbl, ante, cons)
`define PMID_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/pmid_pkg.sv
// Types and constants of the periodic minimum-image distance block.
`default_nettype none
package pmid_pkg;
  localparam int BOX_W      = 31;
  localparam int DISP_W     = 32;
  localparam int DIST_W     = 31;
  localparam int SQ_W       = 62;
  localparam int ROOT_W     = 31;
  localparam int ISQ_REM_W  = 33;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [BOX_W-1:0]         box_t;
  typedef logic signed [DISP_W-1:0] disp_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [ROOT_W-1:0]        root_t;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_BOX_LENGTH = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_t;

  // Box length after reset: 1.0 in Q15.16.
  localparam box_t BOX_RESET = 31'd65536;
endpackage
`default_nettype wire

### design/pmid_lane.sv
// One axis lane: difference, pipelined remainder by the box length, wrap and square.
`default_nettype none
module pmid_lane #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [COORD_WIDTH-1:0] first,
  input  wire logic signed [COORD_WIDTH-1:0] second,
  input  wire pmid_pkg::box_t                box,
  output pmid_pkg::disp_t                    disp,
  output pmid_pkg::sq_t                      sq
);
  import pmid_pkg::*;

  localparam int MW = COORD_WIDTH + 1;

  logic [MW-1:0] diff_w;
  logic [MW-1:0] mag_nxt;
  logic          neg_a_r;
  logic [MW-1:0] mag_a_r;

  logic [BOX_W-1:0] drem_r [MW];
  logic [MW-1:0]    dmag_r [MW];
  logic             dneg_r [MW];

  logic [BOX_W-1:0] rem_fin;
  logic [BOX_W-1:0] len_minus_w;
  disp_t            dm_w;
  disp_t            wrap_nxt;
  disp_t            wrap_r;
  logic signed [2*DISP_W-1:0] prod_w;
  disp_t            disp_r;
  sq_t              sq_r;

  // Signed difference with one guard bit, split into sign and magnitude.
  assign diff_w  = {first[COORD_WIDTH-1], first} - {second[COORD_WIDTH-1], second};
  assign mag_nxt = diff_w[MW-1] ? (~diff_w + 1'b1) : diff_w;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r <= diff_w[MW-1];
      mag_a_r <= mag_nxt;
    end
  end

  // Restoring remainder: one magnitude bit per stage, MSB first.
  for (genvar k = 0; k < MW; k++) begin : g_div
    logic [BOX_W-1:0] rem_in;
    logic [MW-1:0]    mag_in;
    logic             neg_in;
    logic [BOX_W:0]   shf_w;
    logic [BOX_W:0]   sub_w;
    logic [BOX_W-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign mag_in = mag_a_r;
      assign neg_in = neg_a_r;
    end else begin : g_next
      assign rem_in = drem_r[k-1];
      assign mag_in = dmag_r[k-1];
      assign neg_in = dneg_r[k-1];
    end

    assign shf_w   = {rem_in, mag_in[MW-1]};
    assign sub_w   = shf_w - {1'b0, box};
    assign rem_nxt = (shf_w >= {1'b0, box}) ? sub_w[BOX_W-1:0] : shf_w[BOX_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k] <= rem_nxt;
        dmag_r[k] <= {mag_in[MW-2:0], 1'b0};
        dneg_r[k] <= neg_in;
      end
    end
  end

  // Round to nearest with halves away from zero: step one box down when r >= len - r.
  assign rem_fin     = drem_r[MW-1];
  assign len_minus_w = box - rem_fin;
  assign dm_w        = (rem_fin >= len_minus_w) ? ({1'b0, rem_fin} - {1'b0, box})
                                                : {1'b0, rem_fin};
  assign wrap_nxt    = dneg_r[MW-1] ? -dm_w : dm_w;

  always_ff @(posedge clk) begin
    if (en) begin
      wrap_r <= wrap_nxt;
    end
  end

  // Square of the wrapped component; it stays below 2^61.
  assign prod_w = wrap_r * wrap_r;

  always_ff @(posedge clk) begin
    if (en) begin
      disp_r <= wrap_r;
      sq_r   <= prod_w[SQ_W-1:0];
    end
  end

  assign disp = disp_r;
  assign sq   = sq_r;
endmodule
`default_nettype wire

### design/pmid_merge.sv
// Merging stage: sum of the lane squares and a pipelined integer square root.
`default_nettype none
module pmid_merge (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire pmid_pkg::sq_t   sq_x,
  input  wire pmid_pkg::sq_t   sq_y,
  input  wire pmid_pkg::sq_t   sq_z,
  input  wire pmid_pkg::disp_t disp_x_in,
  input  wire pmid_pkg::disp_t disp_y_in,
  input  wire pmid_pkg::disp_t disp_z_in,
  output pmid_pkg::disp_t      disp_x_out,
  output pmid_pkg::disp_t      disp_y_out,
  output pmid_pkg::disp_t      disp_z_out,
  output pmid_pkg::root_t      root
);
  import pmid_pkg::*;

  sq_t   sum_r;
  disp_t dx_r, dy_r, dz_r;

  logic [ISQ_REM_W-1:0] irem_r  [ROOT_W];
  root_t                iroot_r [ROOT_W];
  sq_t                  ival_r  [ROOT_W];
  disp_t                px_r    [ROOT_W];
  disp_t                py_r    [ROOT_W];
  disp_t                pz_r    [ROOT_W];

  // Sum of squares; three terms below 2^60 fit the width.
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sq_x + sq_y + sq_z;
      dx_r  <= disp_x_in;
      dy_r  <= disp_y_in;
      dz_r  <= disp_z_in;
    end
  end

  // Digit-by-digit square root: two radicand bits and one root bit per stage.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [ISQ_REM_W-1:0] rem_in;
    root_t                root_in;
    sq_t                  val_in;
    disp_t                x_in, y_in, z_in;
    logic [ISQ_REM_W+1:0] cand_w;
    logic [ISQ_REM_W+1:0] trial_w;
    logic [ISQ_REM_W+1:0] diff_w;
    logic                 take_w;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = sum_r;
      assign x_in    = dx_r;
      assign y_in    = dy_r;
      assign z_in    = dz_r;
    end else begin : g_next
      assign rem_in  = irem_r[k-1];
      assign root_in = iroot_r[k-1];
      assign val_in  = ival_r[k-1];
      assign x_in    = px_r[k-1];
      assign y_in    = py_r[k-1];
      assign z_in    = pz_r[k-1];
    end

    assign cand_w  = {rem_in, val_in[SQ_W-1:SQ_W-2]};
    assign trial_w = (ISQ_REM_W+2)'({root_in, 2'b01});
    assign diff_w  = cand_w - trial_w;
    assign take_w  = (cand_w >= trial_w);

    always_ff @(posedge clk) begin
      if (en) begin
        irem_r[k]  <= take_w ? diff_w[ISQ_REM_W-1:0] : cand_w[ISQ_REM_W-1:0];
        iroot_r[k] <= {root_in[ROOT_W-2:0], take_w};
        ival_r[k]  <= {val_in[SQ_W-3:0], 2'b00};
        px_r[k]    <= x_in;
        py_r[k]    <= y_in;
        pz_r[k]    <= z_in;
      end
    end
  end

  assign root       = iroot_r[ROOT_W-1];
  assign disp_x_out = px_r[ROOT_W-1];
  assign disp_y_out = py_r[ROOT_W-1];
  assign disp_z_out = pz_r[ROOT_W-1];
endmodule
`default_nettype wire

### design/periodic_min_image_distance_top.sv
// Top level of the periodic minimum-image distance block.
//
//  Channel  Signals                                  Direction  Handshake
//  in       in_first_*/in_second_* (6 x coord)       input      in_valid / in_ready
//  out      out_disp_x/y/z, out_distance             output     out_valid / out_ready
//  cfg      cfg_psel/penable/pwrite/paddr/pwdata     input      APB, cfg_pready tied high
//
// One item enters per cycle while the output is not stalled; three axis lanes run side
// by side into one merging stage. After the input transfer an item passes the input,
// magnitude, COORD_WIDTH + 1 remainder, wrap, square and sum registers in turn,
// then 31 square-root stages and the output register, where out_valid rises.
// A stalled output freezes the whole pipeline; the input register still fills if empty.
// Reset clears valid bits and sets the box length to 1.0; no clearing pass is needed.
`default_nettype none
module periodic_min_image_distance_top #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]     in_first_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_first_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_first_z,
  input  wire logic signed [COORD_WIDTH-1:0]     in_second_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_second_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_second_z,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output pmid_pkg::disp_t                        out_disp_x,
  output pmid_pkg::disp_t                        out_disp_y,
  output pmid_pkg::disp_t                        out_disp_z,
  output logic [pmid_pkg::DIST_W-1:0]            out_distance,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [pmid_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [pmid_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [pmid_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);
  import pmid_pkg::*;

  `include "assert_macros.svh"

  localparam int LAT = COORD_WIDTH + 1 + 3 + 1 + ROOT_W;

  box_t     box_r;
  reg_idx_t cfg_idx_w;
  logic     cfg_wr_w;

  logic adv_w;
  logic v0_r;
  logic [LAT-1:0] vld_r;
  logic out_valid_r;

  logic signed [COORD_WIDTH-1:0] f0_r [3];
  logic signed [COORD_WIDTH-1:0] s0_r [3];
  disp_t lane_disp [3];
  sq_t   lane_sq   [3];

  disp_t mx_w, my_w, mz_w;
  root_t root_w;

  disp_t dx_r, dy_r, dz_r;
  logic [DIST_W-1:0] dist_r;

  // Configuration port: a single register, writes complete in the access cycle.
  assign cfg_idx_w  = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1]);
  assign cfg_wr_w   = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= BOX_RESET;
    end else if (cfg_wr_w && (cfg_idx_w == REG_BOX_LENGTH)) begin
      box_r <= cfg_pwdata[BOX_W-1:0];
    end
  end

  always_comb begin
    case (cfg_idx_w)
      REG_BOX_LENGTH: cfg_prdata = {1'b0, box_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Pipeline advance: the output register is free or its transfer happens now.
  assign adv_w    = !out_valid_r || out_ready;
  assign in_ready = adv_w || !v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        v0_r <= in_valid;
      end
      if (adv_w) begin
        vld_r       <= {vld_r[LAT-2:0], v0_r};
        out_valid_r <= vld_r[LAT-1];
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f0_r[0] <= in_first_x;
      f0_r[1] <= in_first_y;
      f0_r[2] <= in_first_z;
      s0_r[0] <= in_second_x;
      s0_r[1] <= in_second_y;
      s0_r[2] <= in_second_z;
    end
  end

  // Three axis lanes.
  for (genvar a = 0; a < 3; a++) begin : g_lane
    pmid_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk    (clk),
      .en     (adv_w),
      .first  (f0_r[a]),
      .second (s0_r[a]),
      .box    (box_r),
      .disp   (lane_disp[a]),
      .sq     (lane_sq[a])
    );
  end

  pmid_merge u_merge (
    .clk        (clk),
    .en         (adv_w),
    .sq_x       (lane_sq[0]),
    .sq_y       (lane_sq[1]),
    .sq_z       (lane_sq[2]),
    .disp_x_in  (lane_disp[0]),
    .disp_y_in  (lane_disp[1]),
    .disp_z_in  (lane_disp[2]),
    .disp_x_out (mx_w),
    .disp_y_out (my_w),
    .disp_z_out (mz_w),
    .root       (root_w)
  );

  // Output register; a zero box length forces an all-zero result.
  always_ff @(posedge clk) begin
    if (adv_w) begin
      if (box_r == '0) begin
        dx_r   <= '0;
        dy_r   <= '0;
        dz_r   <= '0;
        dist_r <= '0;
      end else begin
        dx_r   <= mx_w;
        dy_r   <= my_w;
        dz_r   <= mz_w;
        dist_r <= root_w;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_disp_x   = dx_r;
  assign out_disp_y   = dy_r;
  assign out_disp_z   = dz_r;
  assign out_distance = dist_r;

  // A stalled output freezes every valid bit behind the input register.
  `PMID_ASSERT_NEXT(a_stall_freeze, !adv_w, $stable(vld_r))
  // An accepted item always lands in the input register.
  `PMID_ASSERT_NEXT(a_in_capture, in_valid && in_ready, v0_r)
  // Zero box length gives an all-zero result; the check covers x, z and the distance.
  `PMID_ASSERT_IMP(a_zero_box, out_valid_r && (box_r == '0),
                   (dx_r == '0) && (dz_r == '0) && (dist_r == '0))
  // The wrapped x component stays within half a box.
  `PMID_ASSERT_IMP(a_half_box, out_valid_r && (box_r != '0),
                   ($signed(dx_r) <= $signed({2'b00, box_r[BOX_W-1:1]})) &&
                   ($signed(dx_r) >= -$signed({2'b00, box_r[BOX_W-1:1]})))
endmodule
`default_nettype wire
